// ----- hw/rtl/bpc_pkg.sv -----
// shared constants and types for the barometric pressure compensation block
package bpc_pkg;

  localparam int unsigned RawW   = 24;
  localparam int unsigned TempW  = 17;
  localparam int unsigned PressW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned TempCoefW = 40;

  // datapath widths: every product of the polynomial fits in AccW signed bits
  localparam int unsigned AccW  = 64;
  localparam int unsigned MulBW = 32;
  localparam int unsigned CntW  = 6;

  localparam logic [RawW-1:0] DisabledMark = 24'h800000;

  localparam logic [CfgIdxW-1:0] RegTempCoef  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressHigh = 2'd2;

  typedef enum logic [4:0] {
    OP_DT2,
    OP_DD,
    OP_DDT3,
    OP_TFIN,
    OP_LL,
    OP_QL,
    OP_P6L,
    OP_P7Q,
    OP_P8C,
    OP_P2L,
    OP_P3Q,
    OP_P4C,
    OP_P10L,
    OP_US,
    OP_UV,
    OP_TU,
    OP_UU,
    OP_P11UU,
    OP_TU2,
    OP_PFIN
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_e;

endpackage

// ----- hw/rtl/bpc_if.sv -----
// channel interfaces: raw sample input, compensated result output, register writes
interface bpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::RawW-1:0]      raw_temperature;
  logic [bpc_pkg::RawW-1:0]      raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpc_pkg::TempW-1:0]   temperature;
  logic [bpc_pkg::PressW-1:0]         pressure;
  logic                               temperature_skipped;
  logic                               pressure_skipped;
  modport source (output valid, output temperature, output pressure,
                  output temperature_skipped, output pressure_skipped, input ready);
  modport sink (input valid, input temperature, input pressure,
                input temperature_skipped, input pressure_skipped, output ready);
endinterface

interface bpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpc_pkg::CfgIdxW-1:0]      index;
  logic [bpc_pkg::CfgDataW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/barometric_pressure_compensation.sv -----
// barometric pressure compensation top level with a shared bit-serial multiplier
//
// in_ch carries one raw temperature / raw pressure pair per item; out_ch returns
// one item with compensated temperature (1/256 degC), pressure (1/64 Pa) and the
// two skipped flags. cfg_ch writes the three calibration registers by index;
// it is always ready, and writes to unused indexes are dropped.
// All multiplications run through one radix-2 shift-add multiplier that retires one
// multiplier bit per cycle, sequenced over up to eighteen products. Each product
// has a load step, its multiply steps over the operand width and a writeback
// step; a disabled temperature skips the temperature steps and a disabled
// pressure skips the pressure products. One item is worked on at a
// time; in_ch.ready is high whenever the sequencer is idle.
// The result sits in an output register, so the next item is accepted while an
// earlier result waits; a stalled receiver only holds the finished item in the
// done state until the output register frees up.
// Reset clears the calibration registers, the kept linear temperature and all
// handshake state; no clearing pass is needed.
module barometric_pressure_compensation (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpc_in_if.sink     in_ch,
  bpc_out_if.source  out_ch,
  bpc_cfg_if.sink    cfg_ch
);

  bpc_pkg::state_e state_q, state_d;
  bpc_pkg::op_e    op_q, op_d;

  logic [bpc_pkg::TempCoefW-1:0] tc_q;
  logic [bpc_pkg::CfgDataW-1:0]  pl_q, ph_q;
  logic signed [31:0]            lt_q;

  logic [bpc_pkg::RawW-1:0]   rp_q;
  logic                       tskip_q, pskip_q;
  logic signed [24:0]         d_q;
  logic signed [bpc_pkg::AccW-1:0] n_q, tmp_q, q_q, c_q, r_q, s_q, v_q, a_q;
  logic signed [bpc_pkg::TempW-1:0] temp_q;
  logic [bpc_pkg::PressW-1:0]      press_q;

  logic signed [bpc_pkg::AccW-1:0]  mcand_q, acc_q;
  logic [bpc_pkg::MulBW-1:0]        mplier_q;
  logic [bpc_pkg::CntW-1:0]         cnt_q, opw_q;

  logic                             out_valid_q;
  logic signed [bpc_pkg::TempW-1:0] out_temp_q;
  logic [bpc_pkg::PressW-1:0]       out_press_q;
  logic                             out_tskip_q, out_pskip_q;

  logic in_acc, out_free, last_bit;

  // calibration fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [17:0] p1m, p2m;
  logic signed [24:0] u_s;
  logic signed [27:0] l_s;

  assign t1  = tc_q[15:0];
  assign t2  = tc_q[31:16];
  assign t3  = tc_q[39:32];
  assign p1  = pl_q[15:0];
  assign p2  = pl_q[31:16];
  assign p3  = pl_q[39:32];
  assign p4  = pl_q[47:40];
  assign p5  = pl_q[63:48];
  assign p6  = ph_q[15:0];
  assign p7  = ph_q[23:16];
  assign p8  = ph_q[31:24];
  assign p9  = ph_q[47:32];
  assign p10 = ph_q[55:48];
  assign p11 = ph_q[63:56];
  assign p1m = 18'(p1) - 18'sd16384;
  assign p2m = 18'(p2) - 18'sd16384;
  assign u_s = $signed({1'b0, rp_q});
  assign l_s = lt_q[27:0];

  // operand selection for the product of the current step
  logic signed [bpc_pkg::AccW-1:0]  opa;
  logic signed [bpc_pkg::MulBW-1:0] opb;
  logic [bpc_pkg::CntW-1:0]         opw;

  always_comb begin
    opa = '0;
    opb = '0;
    opw = '0;
    unique case (op_q)
      bpc_pkg::OP_DT2: begin
        opa = 64'(d_q);
        opb = 32'($signed({1'b0, t2}));
        opw = 6'd17;
      end
      bpc_pkg::OP_DD: begin
        opa = 64'(d_q);
        opb = 32'(d_q);
        opw = 6'd25;
      end
      bpc_pkg::OP_DDT3: begin
        opa = tmp_q;
        opb = 32'(t3);
        opw = 6'd8;
      end
      bpc_pkg::OP_LL: begin
        opa = 64'(l_s);
        opb = 32'(l_s);
        opw = 6'd28;
      end
      bpc_pkg::OP_QL: begin
        opa = q_q >>> 8;
        opb = 32'(l_s);
        opw = 6'd28;
      end
      bpc_pkg::OP_P6L: begin
        opa = 64'(l_s);
        opb = 32'($signed({1'b0, p6}));
        opw = 6'd17;
      end
      bpc_pkg::OP_P7Q: begin
        opa = q_q;
        opb = 32'(p7);
        opw = 6'd8;
      end
      bpc_pkg::OP_P8C: begin
        opa = c_q;
        opb = 32'(p8);
        opw = 6'd8;
      end
      bpc_pkg::OP_P2L: begin
        opa = 64'(l_s);
        opb = 32'(p2m);
        opw = 6'd18;
      end
      bpc_pkg::OP_P3Q: begin
        opa = q_q;
        opb = 32'(p3);
        opw = 6'd8;
      end
      bpc_pkg::OP_P4C: begin
        opa = c_q;
        opb = 32'(p4);
        opw = 6'd8;
      end
      bpc_pkg::OP_P10L: begin
        opa = 64'(l_s);
        opb = 32'(p10);
        opw = 6'd8;
      end
      bpc_pkg::OP_US: begin
        opa = s_q;
        opb = 32'(u_s);
        opw = 6'd25;
      end
      bpc_pkg::OP_UV: begin
        opa = v_q;
        opb = 32'(u_s);
        opw = 6'd25;
      end
      bpc_pkg::OP_TU, bpc_pkg::OP_TU2: begin
        opa = tmp_q;
        opb = 32'(u_s);
        opw = 6'd25;
      end
      bpc_pkg::OP_UU: begin
        opa = 64'(u_s);
        opb = 32'(u_s);
        opw = 6'd25;
      end
      bpc_pkg::OP_P11UU: begin
        opa = tmp_q;
        opb = 32'(p11);
        opw = 6'd8;
      end
      default: begin
        opw = '0;
      end
    endcase
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign last_bit = (cnt_q == opw_q - 6'd1);

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.raw_temperature != bpc_pkg::DisabledMark) begin
            state_d = bpc_pkg::ST_LOAD;
            op_d    = bpc_pkg::OP_DT2;
          end else if (in_ch.raw_pressure != bpc_pkg::DisabledMark) begin
            state_d = bpc_pkg::ST_LOAD;
            op_d    = bpc_pkg::OP_LL;
          end else begin
            state_d = bpc_pkg::ST_DONE;
          end
        end
      end
      bpc_pkg::ST_LOAD: begin
        state_d = (opw == '0) ? bpc_pkg::ST_WB : bpc_pkg::ST_MUL;
      end
      bpc_pkg::ST_MUL: begin
        if (last_bit) begin
          state_d = bpc_pkg::ST_WB;
        end
      end
      bpc_pkg::ST_WB: begin
        priority if (op_q == bpc_pkg::OP_PFIN) begin
          state_d = bpc_pkg::ST_DONE;
        end else if (op_q == bpc_pkg::OP_TFIN && pskip_q) begin
          state_d = bpc_pkg::ST_DONE;
        end else begin
          state_d = bpc_pkg::ST_LOAD;
          op_d    = bpc_pkg::op_e'(5'(op_q + 5'd1));
        end
      end
      bpc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpc_pkg::ST_IDLE;
      op_q        <= bpc_pkg::OP_DT2;
      out_valid_q <= 1'b0;
      tc_q        <= '0;
      pl_q        <= '0;
      ph_q        <= '0;
      lt_q        <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (state_q == bpc_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          bpc_pkg::RegTempCoef:  tc_q <= cfg_ch.data[bpc_pkg::TempCoefW-1:0];
          bpc_pkg::RegPressLow:  pl_q <= cfg_ch.data;
          bpc_pkg::RegPressHigh: ph_q <= cfg_ch.data;
          default: ;
        endcase
      end
      if (state_q == bpc_pkg::ST_WB && op_q == bpc_pkg::OP_TFIN) begin
        lt_q <= 32'((n_q + (64'sd1 <<< 31)) >>> 32);
      end
    end
  end

  // rounding and saturation of the two results
  logic signed [bpc_pkg::AccW-1:0] t_rnd, p_rnd;
  logic signed [bpc_pkg::TempW-1:0] t_sat;
  logic [bpc_pkg::PressW-1:0]       p_sat;

  always_comb begin
    t_rnd = (n_q + (64'sd1 <<< 39)) >>> 40;
    p_rnd = (a_q + 64'sd512) >>> 10;
    priority if (t_rnd > 64'sd65535) begin
      t_sat = 17'sd65535;
    end else if (t_rnd < -64'sd65536) begin
      t_sat = -17'sd65536;
    end else begin
      t_sat = t_rnd[bpc_pkg::TempW-1:0];
    end
    priority if (p_rnd < 64'sd0) begin
      p_sat = '0;
    end else if (p_rnd > 64'sd16777215) begin
      p_sat = '1;
    end else begin
      p_sat = p_rnd[bpc_pkg::PressW-1:0];
    end
  end

  // datapath
  logic signed [bpc_pkg::AccW-1:0] addend;
  assign addend = mplier_q[0] ? mcand_q : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rp_q    <= in_ch.raw_pressure;
      tskip_q <= (in_ch.raw_temperature == bpc_pkg::DisabledMark);
      pskip_q <= (in_ch.raw_pressure == bpc_pkg::DisabledMark);
      d_q     <= 25'($signed({2'b00, in_ch.raw_temperature}) - $signed({2'b00, t1, 8'h00}));
      temp_q  <= '0;
      press_q <= '0;
    end
    unique case (state_q)
      bpc_pkg::ST_LOAD: begin
        mcand_q  <= opa;
        mplier_q <= opb;
        opw_q    <= opw;
        acc_q    <= '0;
        cnt_q    <= '0;
      end
      bpc_pkg::ST_MUL: begin
        // the top bit of the two's complement multiplier weighs negative
        acc_q    <= last_bit ? acc_q - addend : acc_q + addend;
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q + 6'd1;
      end
      bpc_pkg::ST_WB: begin
        unique case (op_q)
          bpc_pkg::OP_DT2:   n_q   <= acc_q <<< 18;
          bpc_pkg::OP_DD:    tmp_q <= acc_q;
          bpc_pkg::OP_DDT3:  n_q   <= n_q + acc_q;
          bpc_pkg::OP_TFIN:  temp_q <= t_sat;
          bpc_pkg::OP_LL:    q_q   <= acc_q >>> 16;
          bpc_pkg::OP_QL:    c_q   <= acc_q >>> 8;
          bpc_pkg::OP_P6L:   r_q   <= $signed(64'(p5) <<< 19) + (acc_q >>> 6);
          bpc_pkg::OP_P7Q:   r_q   <= r_q + (acc_q >>> 8);
          bpc_pkg::OP_P8C:   r_q   <= r_q + (acc_q >>> 15);
          bpc_pkg::OP_P2L:   s_q   <= (64'(p1m) <<< 12) + (acc_q >>> 13);
          bpc_pkg::OP_P3Q:   s_q   <= s_q + (acc_q >>> 16);
          bpc_pkg::OP_P4C:   s_q   <= s_q + (acc_q >>> 21);
          bpc_pkg::OP_P10L:  v_q   <= (64'(p9) <<< 16) + acc_q;
          bpc_pkg::OP_US:    a_q   <= r_q + (acc_q >>> 16);
          bpc_pkg::OP_UV:    tmp_q <= acc_q >>> 24;
          bpc_pkg::OP_TU:    a_q   <= a_q + (acc_q >>> 24);
          bpc_pkg::OP_UU:    tmp_q <= acc_q;
          bpc_pkg::OP_P11UU: tmp_q <= acc_q >>> 25;
          bpc_pkg::OP_TU2:   a_q   <= a_q + (acc_q >>> 24);
          bpc_pkg::OP_PFIN:  press_q <= p_sat;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (state_q == bpc_pkg::ST_DONE && out_free) begin
      out_temp_q  <= temp_q;
      out_press_q <= press_q;
      out_tskip_q <= tskip_q;
      out_pskip_q <= pskip_q;
    end
  end

  assign in_ch.ready  = (state_q == bpc_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid               = out_valid_q;
  assign out_ch.temperature         = out_temp_q;
  assign out_ch.pressure            = out_press_q;
  assign out_ch.temperature_skipped = out_tskip_q;
  assign out_ch.pressure_skipped    = out_pskip_q;

endmodule

// ----- hw/rtl/bpc_checker.sv -----
// port-level checks for the pressure compensation block, bound to the top level
module bpc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [bpc_pkg::TempW-1:0]   temperature_i,
  input logic [bpc_pkg::PressW-1:0]         pressure_i,
  input logic                               temperature_skipped_i,
  input logic                               pressure_skipped_i
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(temperature_i)
      && $stable(pressure_i))
    else $error("stalled result item changed");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && temperature_skipped_i |-> temperature_i == '0)
    else $error("skipped temperature not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pressure_skipped_i |-> pressure_i == '0)
    else $error("skipped pressure not zero");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_ch.valid),
  .in_ready_i            (in_ch.ready),
  .out_valid_i           (out_ch.valid),
  .out_ready_i           (out_ch.ready),
  .temperature_i         (out_ch.temperature),
  .pressure_i            (out_ch.pressure),
  .temperature_skipped_i (out_ch.temperature_skipped),
  .pressure_skipped_i    (out_ch.pressure_skipped)
);

// ----- test/tb_barometric_pressure_compensation.sv -----
// testbench for barometric_pressure_compensation: directed and random samples checked by a predictor
module tb_barometric_pressure_compensation;

  localparam logic [bpc_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam longint PressMax = 64'sd16777215;
  localparam int HoldLen = 3000;

  typedef struct packed {
    logic signed [bpc_pkg::TempW-1:0] temperature;
    logic [bpc_pkg::PressW-1:0]       pressure;
    logic                             temperature_skipped;
    logic                             pressure_skipped;
  } comp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();
  bpc_cfg_if cfg_ch ();

  barometric_pressure_compensation u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [bpc_pkg::TempCoefW-1:0] temp_coef = '0;
  logic [63:0]                   press_lo = '0;
  logic [63:0]                   press_hi = '0;
  int                            kept_lin_temp = 0;

  comp_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;

  function automatic comp_result_t compensate(logic [bpc_pkg::RawW-1:0] rt,
                                              logic [bpc_pkg::RawW-1:0] rp);
    comp_result_t res;
    longint t1, t2, t3, d, n, tout;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint u, l, q, c, rr, s, v, a, pout;
    res = '0;
    res.temperature_skipped = (rt == bpc_pkg::DisabledMark);
    res.pressure_skipped = (rp == bpc_pkg::DisabledMark);
    if (!res.temperature_skipped) begin
      t1 = longint'(temp_coef[15:0]);
      t2 = longint'(temp_coef[31:16]);
      t3 = longint'($signed(temp_coef[39:32]));
      d = longint'(rt) - t1 * 256;
      n = d * t2 * 262144 + d * d * t3;
      kept_lin_temp = int'((n + (longint'(1) << 31)) >>> 32);
      tout = (n + (longint'(1) << 39)) >>> 40;
      if (tout > 65535) tout = 65535;
      if (tout < -65536) tout = -65536;
      res.temperature = tout[bpc_pkg::TempW-1:0];
    end
    if (!res.pressure_skipped) begin
      p1 = longint'($signed(press_lo[15:0]));
      p2 = longint'($signed(press_lo[31:16]));
      p3 = longint'($signed(press_lo[39:32]));
      p4 = longint'($signed(press_lo[47:40]));
      p5 = longint'(press_lo[63:48]);
      p6 = longint'(press_hi[15:0]);
      p7 = longint'($signed(press_hi[23:16]));
      p8 = longint'($signed(press_hi[31:24]));
      p9 = longint'($signed(press_hi[47:32]));
      p10 = longint'($signed(press_hi[55:48]));
      p11 = longint'($signed(press_hi[63:56]));
      u = longint'(rp);
      l = longint'(kept_lin_temp);
      q = (l * l) >>> 16;
      c = ((q >>> 8) * l) >>> 8;
      rr = p5 * 524288 + ((p6 * l) >>> 6) + ((p7 * q) >>> 8) + ((p8 * c) >>> 15);
      s = (p1 - 16384) * 4096 + (((p2 - 16384) * l) >>> 13) + ((p3 * q) >>> 16)
          + ((p4 * c) >>> 21);
      v = p9 * 65536 + p10 * l;
      a = rr + ((u * s) >>> 16) + ((((u * v) >>> 24) * u) >>> 24)
          + ((((p11 * (u * u)) >>> 25) * u) >>> 24);
      pout = (a + 512) >>> 10;
      if (pout < 0) pout = 0;
      if (pout > PressMax) pout = PressMax;
      res.pressure = pout[bpc_pkg::PressW-1:0];
    end
    return res;
  endfunction

  // predictor follows accepted items and register writes
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      pending_results.push_back(compensate(in_ch.raw_temperature, in_ch.raw_pressure));
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        bpc_pkg::RegTempCoef:  temp_coef = cfg_ch.data[bpc_pkg::TempCoefW-1:0];
        bpc_pkg::RegPressLow:  press_lo = cfg_ch.data;
        bpc_pkg::RegPressHigh: press_hi = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    comp_result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: temperature %0d pressure %0d", $time,
                 out_ch.temperature, out_ch.pressure);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.temperature !== exp_res.temperature) begin
          errors++;
          $display("%0t temperature expected %0d actual %0d", $time,
                   exp_res.temperature, out_ch.temperature);
        end
        if (out_ch.pressure !== exp_res.pressure) begin
          errors++;
          $display("%0t pressure expected %0d actual %0d", $time,
                   exp_res.pressure, out_ch.pressure);
        end
        if (out_ch.temperature_skipped !== exp_res.temperature_skipped) begin
          errors++;
          $display("%0t temperature_skipped expected %0b actual %0b", $time,
                   exp_res.temperature_skipped, out_ch.temperature_skipped);
        end
        if (out_ch.pressure_skipped !== exp_res.pressure_skipped) begin
          errors++;
          $display("%0t pressure_skipped expected %0b actual %0b", $time,
                   exp_res.pressure_skipped, out_ch.pressure_skipped);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= HoldLen - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input logic [bpc_pkg::RawW-1:0] rt,
                             input logic [bpc_pkg::RawW-1:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure <= rp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bpc_pkg::CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(input logic [63:0] tc, input logic [63:0] lo,
                            input logic [63:0] hi);
    write_reg(bpc_pkg::RegTempCoef, tc);
    write_reg(bpc_pkg::RegPressLow, lo);
    write_reg(bpc_pkg::RegPressHigh, hi);
  endtask

  // raw count mostly near a center, sometimes anywhere, sometimes disabled
  function automatic logic [bpc_pkg::RawW-1:0] pick_raw(logic [bpc_pkg::RawW-1:0] center);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) return bpc_pkg::DisabledMark;
    if (sel < 25) return (bpc_pkg::RawW)'($urandom);
    return center + (bpc_pkg::RawW)'($urandom_range(131071)) - (bpc_pkg::RawW)'(65536);
  endfunction

  // plausible calibration set so that most results are not saturated
  task automatic load_plausible();
    logic [15:0] t1;
    t1 = 16'(27000 + $urandom_range(2000));
    load_coefs({24'($urandom), 8'($signed(-$urandom_range(12))),
                16'(18000 + $urandom_range(3000)), t1},
               {16'(20000 + $urandom_range(5000)), 8'($urandom), 8'($urandom),
                16'(2000 + $urandom_range(4000)), 16'($urandom)},
               {8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 16'(30000 + $urandom_range(10000))});
  endtask

  task automatic random_burst(input int count);
    logic [bpc_pkg::RawW-1:0] tc, pc;
    tc = {temp_coef[15:0], 8'($urandom)};
    pc = (bpc_pkg::RawW)'(6000000 + $urandom_range(4000000));
    repeat (count) send_sample(pick_raw(tc), pick_raw(pc));
  endtask

  task automatic test_directed();
    logic [bpc_pkg::RawW-1:0] edge_vals[6];
    edge_vals = '{24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800001, bpc_pkg::DisabledMark,
                  24'h6B5A00};
    // pressure before any temperature uses the reset linear temperature
    write_reg(bpc_pkg::RegPressLow, {16'd25000, 8'h10, 8'hF0, 16'hF000, 16'h7000});
    send_sample(bpc_pkg::DisabledMark, 24'h600000);
    send_sample(bpc_pkg::DisabledMark, bpc_pkg::DisabledMark);
    wait_idle();
    load_coefs(64'h00_F9_4A96_6CAC, 64'h6500_03_F9_0F00_E000, 64'hF3_05_0ABC_FA_03_7A00);
    write_reg(RegUnused, {$urandom, $urandom});
    foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[5 - i]);
    send_sample(24'h6CAC00 + 24'd4000, 24'h700000);
    send_sample(bpc_pkg::DisabledMark, 24'h6A0000);
    wait_idle();
    // coefficient extremes: all registers set to all ones, saturating most temperatures
    load_coefs({64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[i]);
    wait_idle();
    load_coefs(64'h0, 64'h0, 64'h0);
    foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[(i + 2) % 6]);
    wait_idle();
    load_coefs(64'h7F_FFFF_0000, 64'hFFFF_7F_7F_7FFF_7FFF, 64'h7F_7F_7FFF_7F_7F_FFFF);
    foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[(i + 3) % 6]);
    wait_idle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(9) < 2)
        load_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      else
        load_plausible();
      random_burst(count / 4);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_plausible();
    hold_req <= ~hold_req;
    random_burst(40);
    wait_idle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 420);
    test_random_phase(85, 0, 400);
    test_random_phase(0, 85, 400);
    test_random_phase(22, 22, 400);
    test_backpressure();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_barometric_pressure_compensation passed");
    end else begin
      $display("tb_barometric_pressure_compensation failed");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb_barometric_pressure_compensation failed");
    $finish;
  end

endmodule
